// ----- src/hmrgb_pkg.sv -----
// Shared constants and the gamma lookup function for the heat-map color pipeline.
package hmrgb_pkg;

    localparam int DEF_VALUE_BITS = 16;
    localparam int DEF_FRAC_BITS  = 12;

    // configuration register indexes
    localparam logic [1:0] CFG_LOWER = 2'd0;
    localparam logic [1:0] CFG_UPPER = 2'd1;
    localparam logic [1:0] CFG_MODE  = 2'd2;

    // reshaping curves
    localparam logic [1:0] MODE_LOG  = 2'd1;
    localparam logic [1:0] MODE_SQRT = 2'd2;

    // wavelength offsets above 380 nm, Q9.6
    localparam int SPAN_W   = 25600;
    localparam int W_BLUE   = 3840;
    localparam int W_CYAN   = 7040;
    localparam int W_GREEN  = 8320;
    localparam int W_YELLOW = 12800;
    localparam int W_RED    = 16960;
    localparam int W_RISE   = 2560;
    localparam int W_FALL   = 20480;

    localparam logic [10:0] CH_ONE = 11'd1024;

    // reciprocal division by small constants: q = (n * floor(2^S / d)) >> S, one correction
    localparam int          RCP_SHIFT = 24;
    localparam logic [24:0] RCP_1  = 25'(1 << RCP_SHIFT);
    localparam logic [24:0] RCP_5  = 25'((1 << RCP_SHIFT) / 5);
    localparam logic [24:0] RCP_15 = 25'((1 << RCP_SHIFT) / 15);
    localparam logic [24:0] RCP_25 = 25'((1 << RCP_SHIFT) / 25);
    localparam logic [24:0] RCP_35 = 25'((1 << RCP_SHIFT) / 35);
    localparam logic [24:0] RCP_50 = 25'((1 << RCP_SHIFT) / 50);
    localparam logic [24:0] RCP_65 = 25'((1 << RCP_SHIFT) / 65);

    localparam logic [6:0] DEN_1  = 7'd1;
    localparam logic [6:0] DEN_5  = 7'd5;
    localparam logic [6:0] DEN_15 = 7'd15;
    localparam logic [6:0] DEN_25 = 7'd25;
    localparam logic [6:0] DEN_35 = 7'd35;
    localparam logic [6:0] DEN_50 = 7'd50;
    localparam logic [6:0] DEN_65 = 7'd65;

    // gamma 0.8 knots, 32 intervals over 0..1024
    function automatic logic [7:0] gamma_knot(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'd0;
            6'd1:  v = 8'd16;
            6'd2:  v = 8'd28;
            6'd3:  v = 8'd38;
            6'd4:  v = 8'd48;
            6'd5:  v = 8'd58;
            6'd6:  v = 8'd67;
            6'd7:  v = 8'd76;
            6'd8:  v = 8'd84;
            6'd9:  v = 8'd92;
            6'd10: v = 8'd101;
            6'd11: v = 8'd109;
            6'd12: v = 8'd116;
            6'd13: v = 8'd124;
            6'd14: v = 8'd132;
            6'd15: v = 8'd139;
            6'd16: v = 8'd146;
            6'd17: v = 8'd154;
            6'd18: v = 8'd161;
            6'd19: v = 8'd168;
            6'd20: v = 8'd175;
            6'd21: v = 8'd182;
            6'd22: v = 8'd189;
            6'd23: v = 8'd196;
            6'd24: v = 8'd203;
            6'd25: v = 8'd209;
            6'd26: v = 8'd216;
            6'd27: v = 8'd223;
            6'd28: v = 8'd229;
            6'd29: v = 8'd236;
            6'd30: v = 8'd242;
            6'd31: v = 8'd249;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

// ----- src/heatmap_value_to_rgb.sv -----
// Heat-map colormap: sample value to 8-bit RGB through a fixed-depth pipeline.
//
//  channel   direction  handshake                     word
//  -------   ---------  ----------------------------  -------------------------
//  sample    in         start (busy always low)       i_sample_value
//  result    out        o_result_valid strobe         o_red, o_green, o_blue
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_addr, i_cfg_data
//
//  One word enters per clock; results come out in input order.
//  Depth is set by the restoring divider (one quotient bit per stage) and the
//  log2 / sqrt units (one squaring or one root digit per stage).
//  Reset (synchronous, active low) clears the valid chain and the config registers.
//  Nothing stalls: the result strobe lasts one cycle and must be taken.
module heatmap_value_to_rgb #(
    parameter int VALUE_BITS = hmrgb_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS  = hmrgb_pkg::DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_sample_value,
    output logic                  o_result_valid,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_addr,
    input  logic [VALUE_BITS-1:0] i_cfg_data
);
    import hmrgb_pkg::*;

    localparam int V   = VALUE_BITS;
    localparam int F   = FRAC_BITS;
    localparam int LAT = 2 * F + 9;
    localparam int SW  = 2 * F + 2;
    localparam logic [F:0] ONE_T = (F + 1)'(1) << F;

    // ---------------- configuration ----------------
    logic [V-1:0] r_lower;
    logic [V-1:0] r_upper;
    logic [1:0]   r_mode;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '1;
            r_mode  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // span and its magnitude; the user keeps them static while words are in flight (not enforced here)
    logic signed [V:0] w_den;
    logic        [V-1:0] w_dabs;
    assign w_den  = $signed({1'b0, r_upper}) - $signed({1'b0, r_lower});
    assign w_dabs = w_den[V] ? V'(-w_den) : w_den[V-1:0];

    // ---------------- valid chain ----------------
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start && !busy};
        end
    end
    assign o_result_valid = r_vld[LAT-1];

    // ---------------- input and normalize setup ----------------
    logic [V-1:0] r_v;
    logic [V-1:0] r_s2_rem;
    logic         r_s2_zero;
    logic         r_s2_one;
    logic signed [V:0] n_num;
    logic signed [V:0] n_a;

    always_ff @(posedge i_clk) begin
        r_v <= i_sample_value;
    end

    always_comb begin
        n_num = $signed({1'b0, r_v}) - $signed({1'b0, r_lower});
        n_a   = w_den[V] ? -n_num : n_num;
    end

    always_ff @(posedge i_clk) begin
        r_s2_zero <= (w_den == '0) || (n_a <= 0);
        r_s2_one  <= n_a >= $signed({1'b0, w_dabs});
        r_s2_rem  <= n_a[V-1:0];
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [V-1:0] r_drem [F];
    logic [F-1:0] r_dq   [F];
    logic         r_dz   [F];
    logic         r_do   [F];

    for (genvar k = 0; k < F; k++) begin : g_div
        logic [V-1:0] prev_rem;
        logic [F-1:0] prev_q;
        logic         prev_z;
        logic         prev_o;
        logic [V:0]   n_shl;
        logic         n_bit;

        if (k == 0) begin : g_first
            assign prev_rem = r_s2_rem;
            assign prev_q   = '0;
            assign prev_z   = r_s2_zero;
            assign prev_o   = r_s2_one;
        end else begin : g_next
            assign prev_rem = r_drem[k-1];
            assign prev_q   = r_dq[k-1];
            assign prev_z   = r_dz[k-1];
            assign prev_o   = r_do[k-1];
        end

        always_comb begin
            n_shl = {prev_rem, 1'b0};
            n_bit = n_shl >= {1'b0, w_dabs};
        end

        always_ff @(posedge i_clk) begin
            r_drem[k] <= n_bit ? V'(n_shl - {1'b0, w_dabs}) : n_shl[V-1:0];
            r_dq[k]   <= prev_q | (F'(n_bit) << (F - 1 - k));
            r_dz[k]   <= prev_z;
            r_do[k]   <= prev_o;
        end
    end

    // equal bounds raise the zero flag; if both flags are up, zero wins
    logic [F:0] w_t;
    assign w_t = r_dz[F-1] ? '0 : (r_do[F-1] ? ONE_T : {1'b0, r_dq[F-1]});

    // ---------------- reshape: log2(1+t) by squaring, sqrt by root digits ----------------
    logic [F:0]    r_lx [F+1];
    logic [F-1:0]  r_lr [F+1];
    logic          r_ls [F+1];
    logic [SW-1:0] r_sn [F+1];
    logic [SW-1:0] r_sr [F+1];
    logic [F:0]    r_tl [F+1];

    for (genvar k = 0; k <= F; k++) begin : g_shape
        logic [F:0]      prev_x;
        logic [F-1:0]    prev_lr;
        logic            prev_ls;
        logic [SW-1:0]   prev_n;
        logic [SW-1:0]   prev_r;
        logic [F:0]      prev_t;
        logic [2*F+1:0]  n_sq;
        logic [F+1:0]    n_xs;
        logic [SW-1:0]   n_try;
        logic            n_fit;

        if (k == 0) begin : g_first
            assign prev_x  = (F + 1)'({1'b0, w_t} + {1'b0, ONE_T});
            assign prev_lr = '0;
            assign prev_ls = w_t[F];
            assign prev_n  = SW'(w_t) << F;
            assign prev_r  = '0;
            assign prev_t  = w_t;
        end else begin : g_next
            assign prev_x  = r_lx[k-1];
            assign prev_lr = r_lr[k-1];
            assign prev_ls = r_ls[k-1];
            assign prev_n  = r_sn[k-1];
            assign prev_r  = r_sr[k-1];
            assign prev_t  = r_tl[k-1];
        end

        always_comb begin
            n_sq  = (2 * F + 2)'(prev_x) * (2 * F + 2)'(prev_x);
            n_xs  = n_sq[2*F+1:F];
            n_try = prev_r + (SW'(1) << (2 * (F - k)));
            n_fit = prev_n >= n_try;
        end

        always_ff @(posedge i_clk) begin
            if (k < F) begin
                r_lx[k] <= n_xs[F+1] ? n_xs[F+1:1] : n_xs[F:0];
                r_lr[k] <= prev_lr | (F'(n_xs[F+1]) << (F - 1 - k));
            end else begin
                r_lx[k] <= prev_x;
                r_lr[k] <= prev_lr;
            end
            r_ls[k] <= prev_ls;
            r_sn[k] <= n_fit ? prev_n - n_try : prev_n;
            r_sr[k] <= n_fit ? (prev_r >> 1) + (SW'(1) << (2 * (F - k))) : prev_r >> 1;
            r_tl[k] <= prev_t;
        end
    end

    // ---------------- curve select and wavelength ----------------
    logic [F:0]    n_tsel;
    logic [F+15:0] n_wprod;
    logic [14:0]   r_w;

    always_comb begin
        case (r_mode)
            MODE_LOG:  n_tsel = r_ls[F] ? ONE_T : {1'b0, r_lr[F]};
            MODE_SQRT: n_tsel = (r_sr[F] > SW'(ONE_T)) ? ONE_T : r_sr[F][F:0];
            default:   n_tsel = r_tl[F];
        endcase
        n_wprod = (F + 16)'(n_tsel) * (F + 16)'(SPAN_W);
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_wprod[F+14:F];
    end

    // ---------------- spectral segments: lanes red, green, blue, falloff ----------------
    logic [16:0] n_cn [4];
    logic [24:0] n_cm [4];
    logic [6:0]  n_cd [4];
    logic [16:0] r_cn [4];
    logic [24:0] r_cm [4];
    logic [6:0]  r_cd [4];
    logic [16:0] w17;

    assign w17 = 17'(r_w);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_cn[i] = '0;
            n_cm[i] = RCP_1;
            n_cd[i] = DEN_1;
        end
        if (r_w < 15'(W_BLUE)) begin
            n_cn[0] = 17'((17'(W_BLUE) - w17) << 2);
            n_cm[0] = RCP_15;  n_cd[0] = DEN_15;
            n_cn[2] = 17'(CH_ONE);
        end else if (r_w < 15'(W_CYAN)) begin
            n_cn[1] = 17'((w17 - 17'(W_BLUE)) << 3);
            n_cm[1] = RCP_25;  n_cd[1] = DEN_25;
            n_cn[2] = 17'(CH_ONE);
        end else if (r_w < 15'(W_GREEN)) begin
            n_cn[1] = 17'(CH_ONE);
            n_cn[2] = 17'((17'(W_GREEN) - w17) << 2);
            n_cm[2] = RCP_5;   n_cd[2] = DEN_5;
        end else if (r_w < 15'(W_YELLOW)) begin
            n_cn[0] = 17'((w17 - 17'(W_GREEN)) << 3);
            n_cm[0] = RCP_35;  n_cd[0] = DEN_35;
            n_cn[1] = 17'(CH_ONE);
        end else if (r_w < 15'(W_RED)) begin
            n_cn[0] = 17'(CH_ONE);
            n_cn[1] = 17'((17'(W_RED) - w17) << 4);
            n_cm[1] = RCP_65;  n_cd[1] = DEN_65;
        end else begin
            n_cn[0] = 17'(CH_ONE);
        end

        // edge falloff, reduced fractions of the linear ramps
        if (r_w < 15'(W_RISE)) begin
            n_cn[3] = 17'd7680 + 17'd7 * w17;
            n_cm[3] = RCP_25;  n_cd[3] = DEN_25;
        end else if (r_w < 15'(W_FALL)) begin
            n_cn[3] = 17'(CH_ONE);
        end else begin
            n_cn[3] = 17'd15360 + 17'd7 * (17'(SPAN_W) - w17);
            n_cm[3] = RCP_50;  n_cd[3] = DEN_50;
        end
    end

    logic [10:0] r_q0  [4];
    logic [16:0] r_cn2 [4];
    logic [6:0]  r_cd2 [4];
    logic [10:0] r_qc  [4];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        logic [41:0] n_prod;
        logic [17:0] n_qd;
        logic [17:0] n_rem;

        always_comb begin
            n_prod = 42'(r_cn[i]) * 42'(r_cm[i]);
            n_qd   = 18'(r_q0[i]) * 18'(r_cd2[i]);
            n_rem  = 18'(r_cn2[i]) - n_qd;
        end

        always_ff @(posedge i_clk) begin
            r_cn[i]  <= n_cn[i];
            r_cm[i]  <= n_cm[i];
            r_cd[i]  <= n_cd[i];
            r_q0[i]  <= n_prod[RCP_SHIFT+10:RCP_SHIFT];
            r_cn2[i] <= r_cn[i];
            r_cd2[i] <= r_cd[i];
            r_qc[i]  <= (n_rem >= 18'(r_cd2[i])) ? r_q0[i] + 11'd1 : r_q0[i];
        end
    end

    // ---------------- intensity product and gamma ----------------
    logic [10:0] r_p   [3];
    logic [7:0]  r_out [3];

    for (genvar i = 0; i < 3; i++) begin : g_gamma
        logic [21:0] n_pf;
        logic [5:0]  n_idx;
        logic [7:0]  n_lo;
        logic [7:0]  n_hi;
        logic [12:0] n_mix;

        always_comb begin
            n_pf  = 22'(r_qc[i]) * 22'(r_qc[3]);
            n_idx = {1'b0, r_p[i][9:5]};
            n_lo  = gamma_knot(n_idx);
            n_hi  = gamma_knot(n_idx + 6'd1);
            n_mix = 13'(n_hi - n_lo) * 13'(r_p[i][4:0]) + 13'd16;
        end

        always_ff @(posedge i_clk) begin
            r_p[i]   <= n_pf[20:10];
            r_out[i] <= r_p[i][10] ? 8'd255 : n_lo + n_mix[12:5];
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

// ----- tb/heatmap_checker.sv -----
// Checker for the heat-map colormap: tracks config, predicts colors, compares results.
module heatmap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [15:0] i_sample_value,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_result_valid,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output int          o_outstanding,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import hmrgb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam longint ONE_T = 4096;
    localparam int KNOTS [33] = '{
        0, 16, 28, 38, 48, 58, 67, 76, 84, 92, 101, 109, 116, 124, 132, 139,
        146, 154, 161, 168, 175, 182, 189, 196, 203, 209, 216, 223, 229, 236,
        242, 249, 255
    };

    logic [15:0] lower_q;
    logic [15:0] upper_q;
    logic [1:0]  mode_q;
    rgb_t        color_fifo[$];

    function automatic longint norm_sample(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
        longint num;
        longint den;
        num = longint'(v) - longint'(lo);
        den = longint'(hi) - longint'(lo);
        if (den > 0) begin
            if (num <= 0) return 0;
            if (num >= den) return ONE_T;
            return (num * ONE_T) / den;
        end
        if (den < 0) begin
            if (num >= 0) return 0;
            if (num <= den) return ONE_T;
            return (-num * ONE_T) / (-den);
        end
        return 0;
    endfunction

    function automatic longint log_curve(longint t);
        longint x;
        longint r;
        x = ONE_T + t;
        r = 0;
        if (x >= 2 * ONE_T) return ONE_T;
        for (int b = 11; b >= 0; b--) begin
            x = (x * x) >> 12;
            if (x >= 2 * ONE_T) begin
                x = x >> 1;
                r = r | (longint'(1) << b);
            end
        end
        return r;
    endfunction

    function automatic longint root_curve(longint n);
        longint r;
        longint bt;
        r = 0;
        bt = longint'(1) << 30;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n = n - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] gamma_scale(longint p);
        longint lo;
        longint hi;
        if (p >= 1024) return 8'd255;
        lo = KNOTS[p >> 5];
        hi = KNOTS[(p >> 5) + 1];
        return 8'(lo + (((hi - lo) * (p & 31) + 16) >> 5));
    endfunction

    function automatic rgb_t color_of(logic [15:0] v);
        longint t;
        longint w;
        longint r;
        longint g;
        longint b;
        longint f;
        rgb_t c;
        t = norm_sample(v, lower_q, upper_q);
        if (mode_q == MODE_LOG) t = log_curve(t);
        else if (mode_q == MODE_SQRT) t = root_curve(t << 12);
        if (t > ONE_T) t = ONE_T;
        w = (t * SPAN_W) >> 12;
        if (w < W_BLUE) begin
            r = (W_BLUE - w) * 1024 / 3840; g = 0; b = 1024;
        end else if (w < W_CYAN) begin
            r = 0; g = (w - W_BLUE) * 1024 / 3200; b = 1024;
        end else if (w < W_GREEN) begin
            r = 0; g = 1024; b = (W_GREEN - w) * 1024 / 1280;
        end else if (w < W_YELLOW) begin
            r = (w - W_GREEN) * 1024 / 4480; g = 1024; b = 0;
        end else if (w < W_RED) begin
            r = 1024; g = (W_RED - w) * 1024 / 4160; b = 0;
        end else begin
            r = 1024; g = 0; b = 0;
        end
        // intensity falls off toward both ends of the spectrum
        if (w < W_RISE) f = (3072 * 2560 + 7168 * w) / 25600;
        else if (w < W_FALL) f = 1024;
        else f = (3072 * 5120 + 7168 * (SPAN_W - w)) / 51200;
        c.red   = gamma_scale((r * f) >> 10);
        c.green = gamma_scale((g * f) >> 10);
        c.blue  = gamma_scale((b * f) >> 10);
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        rgb_t exp_c;
        logic acc;
        logic ret;
        acc = 1'b0;
        ret = 1'b0;
        if (!i_rst_n) begin
            lower_q <= 16'd0;
            upper_q <= 16'hFFFF;
            mode_q  <= 2'd0;
        end else begin
            if (i_start && !i_busy) begin
                color_fifo.push_back(color_of(i_sample_value));
                acc = 1'b1;
            end
            if (i_result_valid) begin
                ret = 1'b1;
                if (color_fifo.size() == 0) begin
                    report_mismatch("unexpected word, red", i_red, 0);
                end else begin
                    exp_c = color_fifo.pop_front();
                    if (i_red !== exp_c.red) report_mismatch("red", i_red, exp_c.red);
                    if (i_green !== exp_c.green)
                        report_mismatch("green", i_green, exp_c.green);
                    if (i_blue !== exp_c.blue) report_mismatch("blue", i_blue, exp_c.blue);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_LOWER: lower_q <= i_cfg_data;
                    CFG_UPPER: upper_q <= i_cfg_data;
                    CFG_MODE:  mode_q  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding <= o_outstanding + int'(acc) - int'(ret && o_outstanding > 0);
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the heat-map colormap testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hmrgb_pkg::*;

    localparam int LATENCY = 33;
    localparam int LIMIT   = 200000;
    localparam int PHASES  = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_sample_value = '0;
    logic        o_result_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;
    int          outstanding;
    int          fail_count;
    int          cycles = 0;
    logic        allow_idle = 1'b1;

    logic [15:0] phase_lower [PHASES] = '{0, 0, 0, 1000, 300, 60000, 100, 65535, 12345, 0};
    logic [15:0] phase_upper [PHASES] = '{65535, 65535, 65535, 50000, 300, 100, 4196, 0,
                                          12346, 65535};
    logic [1:0]  phase_mode  [PHASES] = '{0, MODE_LOG, MODE_SQRT, 3, 0, MODE_LOG, MODE_SQRT,
                                          0, MODE_LOG, 0};
    logic [15:0] directed [16] = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFE,
                                   16'h8000, 16'h4000, 16'hC000, 16'h5555, 16'hAAAA,
                                   16'h0F5C, 16'h2CCC, 16'h5333, 16'h7FFF, 16'hD47A,
                                   16'hE666};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    heatmap_value_to_rgb dut (
        .i_clk, .i_rst_n, .start, .busy, .i_sample_value,
        .o_result_valid, .o_red, .o_green, .o_blue,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_addr, .i_cfg_data
    );

    heatmap_checker checker_i (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_sample_value,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_addr, .i_cfg_data,
        .i_result_valid(o_result_valid), .i_red(o_red), .i_green(o_green),
        .i_blue(o_blue), .o_outstanding(outstanding), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(logic [15:0] v);
        i_sample_value <= v;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (allow_idle && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // drop start and wait until every color in flight has come back
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // valid stays up so writes can follow back to back; the caller drops it
    task automatic write_reg(logic [1:0] addr, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin
        logic [15:0] lo_b;
        logic [15:0] hi_b;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_word(directed[i]);
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(CFG_LOWER, phase_lower[p]);
            write_reg(CFG_UPPER, phase_upper[p]);
            write_reg(CFG_MODE, {14'd0, phase_mode[p]});
            i_cfg_valid <= 1'b0;
            lo_b = (phase_lower[p] < phase_upper[p]) ? phase_lower[p] : phase_upper[p];
            hi_b = (phase_lower[p] < phase_upper[p]) ? phase_upper[p] : phase_lower[p];
            allow_idle = (p != PHASES - 1);
            send_word(phase_lower[p]);
            send_word(phase_upper[p]);
            send_word(16'h0000);
            send_word(16'hFFFF);
            for (int i = 0; i < 60; i++) begin
                if ($urandom_range(2) == 0) send_word(16'($urandom));
                else send_word(16'($urandom_range(hi_b, lo_b)));
            end
        end
        drain();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
